/* design/bpa_pkg.sv */
// Shared types, constants and codes of the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

  localparam int MaxPages  = 32768;
  localparam int MaxRank   = 16;
  localparam int PageShift = 12;
  localparam int AddrW     = 48;
  localparam int IdxW      = $clog2(MaxPages);
  localparam int CntW      = 16;
  localparam int RankW     = 5;
  localparam int LinkW     = IdxW + 1;
  localparam int LvlIdxW   = $clog2(MaxRank);

  localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [1:0] CFG_PAGE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_QRANK  = 2'd2,
    MODE_QCOUNT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETK,
    OP_POP1,
    OP_POP2,
    OP_PUSH1,
    OP_PUSH2,
    OP_UNLINK1,
    OP_UNLINK2,
    OP_DEC,
    OP_RANGE_START,
    OP_RANGE_STEP,
    OP_MARK,
    OP_READ_CUR,
    OP_FSTART,
    OP_READ_B,
    OP_MERGE,
    OP_RES_ERR,
    OP_RES_ALLOC,
    OP_RES_RANK,
    OP_RES_COUNT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_SWEEP,
    S_A_CHECK,
    S_A_SPOP2,
    S_A_DEC,
    S_A_PUSHH1,
    S_A_PUSHH2,
    S_A_PUSHL1,
    S_A_PUSHL2,
    S_A_RSTART,
    S_A_RANGE,
    S_A_FPOP2,
    S_A_MARK,
    S_A_RES,
    S_F_RD,
    S_F_CHECK,
    S_F_BUD,
    S_F_UNL2,
    S_F_MERGE,
    S_F_RSTART,
    S_F_RANGE,
    S_F_PUSH2,
    S_F_RES,
    S_Q_RD
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t res;
    logic    sel_hi;
    logic    dbl;
  } dp_cmd_t;

  typedef struct packed {
    logic  init_start;
    logic  range_done;
    logic  rank_ok;
    logic  found;
    logic  addr_ok;
    mode_t mode;
    logic  lvl_gt_rank;
    logic  lvl_below_max;
    logic  buddy_in_pool;
    logic  blk_ok;
    logic  rank_zero;
    logic  buddy_free;
    logic  out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* design/bpa_req_if.sv */
// Request channel interface of the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [4:0]  rank;
  logic [47:0] address;
  modport source (output valid, mode, rank, address, input ready);
  modport sink (input valid, mode, rank, address, output ready);
endinterface
`default_nettype wire

/* design/bpa_rsp_if.sv */
// Response channel interface of the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] block_addr;
  logic [15:0] query_value;
  modport source (output valid, status, block_addr, query_value, input ready);
  modport sink (input valid, status, block_addr, query_value, output ready);
endinterface
`default_nettype wire

/* design/bpa_cfg_if.sv */
// Configuration write channel interface of the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
interface bpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/bpa_datapath.sv */
// Datapath of the buddy page allocator: free lists, link and rank memories, range writer.
`timescale 1ns / 1ps
`default_nettype none
module bpa_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bpa_pkg::dp_cmd_t  cmd,
  output bpa_pkg::dp_stat_t      stat,
  input  wire logic [1:0]        req_mode,
  input  wire logic [4:0]        req_rank,
  input  wire logic [47:0]       req_address,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [47:0]       cfg_data,
  output logic                   rsp_valid,
  output logic [1:0]             rsp_status,
  output logic [47:0]            rsp_block_addr,
  output logic [15:0]            rsp_query_value,
  input  wire logic              rsp_ready
);
  import bpa_pkg::*;

  logic [LinkW-1:0]     next_mem [MaxPages];
  logic [LinkW-1:0]     prev_mem [MaxPages];
  logic [RankW:0]       rank_mem [MaxPages];

  logic [AddrW-1:0]     pool_base;
  logic [CntW-1:0]      pool_pages;
  logic [RankW-1:0]     top_rank;
  mode_t                mode_q;
  logic [RankW-1:0]     rank_q;
  logic [AddrW-1:0]     addr_q;
  logic [IdxW-1:0]      cur;
  logic [IdxW-1:0]      b;
  logic [RankW-1:0]     lvl;
  logic [LinkW-1:0]     head [MaxRank];
  logic [CntW-1:0]      fcount [MaxRank];
  logic [IdxW-1:0]      rng_base;
  logic [CntW-1:0]      rng_len;
  logic [CntW-1:0]      rng_cnt;
  logic [RankW-1:0]     rng_val;
  logic                 rng_sweep;

  logic [LinkW-1:0]     next_rd;
  logic [LinkW-1:0]     prev_rd;
  logic [RankW:0]       rank_rd;

  logic                 nm_we, pm_we, rm_we;
  logic [IdxW-1:0]      nm_wa, pm_wa, rm_wa, nm_ra, pm_ra, rm_ra;
  logic [LinkW-1:0]     nm_wd, pm_wd;
  logic [RankW:0]       rm_wd;

  logic                 pc_wr;
  logic [CntW-1:0]      pp_new;
  logic [RankW-1:0]     top_new;
  logic [LvlIdxW-1:0]   li;
  logic [LvlIdxW-1:0]   qi;
  logic [LinkW-1:0]     h;
  logic [CntW-1:0]      half;
  logic [CntW-1:0]      top_size;
  logic [IdxW-1:0]      push_a;
  logic [IdxW-1:0]      b_c;
  logic [AddrW-1:0]     off;
  logic [IdxW-1:0]      idx_dec;
  logic                 rng_done;
  logic [RankW-1:0]     found_k;
  logic                 found;

  function automatic logic [AddrW-1:0] req_off(input logic [AddrW-1:0] a,
                                               input logic [AddrW-1:0] base);
    req_off = a - base;
  endfunction

  always_comb begin
    pc_wr   = cfg_valid && (cfg_index == CFG_PAGE_COUNT);
    pp_new  = (cfg_data[CntW-1:0] > CntW'(MaxPages)) ? CntW'(MaxPages) : cfg_data[CntW-1:0];
    top_new = '0;
    for (int i = 0; i < CntW; i++) begin
      if (pp_new[i]) begin
        top_new = RankW'(i + 1);
      end
    end
    if (top_new > RankW'(MaxRank)) begin
      top_new = RankW'(MaxRank);
    end
    li       = LvlIdxW'(lvl - 5'd1);
    qi       = LvlIdxW'(rank_q - 5'd1);
    h        = head[li];
    half     = CntW'(17'd1 << (lvl - 5'd1));
    top_size = CntW'(17'd1 << (top_rank - 5'd1));
    push_a   = cmd.sel_hi ? (cur + half[IdxW-1:0]) : cur;
    b_c      = cur ^ half[IdxW-1:0];
    off      = req_off(addr_q, pool_base);
    idx_dec  = off[PageShift+IdxW-1:PageShift];
    rng_done = (rng_cnt == rng_len);
    found_k  = '0;
    found    = 1'b0;
    for (int j = MaxRank - 1; j >= 0; j--) begin
      if (head[j][LinkW-1] && (RankW'(j + 1) >= rank_q)) begin
        found_k = RankW'(j + 1);
        found   = 1'b1;
      end
    end
  end

  always_comb begin
    stat.init_start    = pc_wr;
    stat.range_done    = rng_done;
    stat.rank_ok       = (rank_q != '0) && (rank_q <= RankW'(MaxRank));
    stat.found         = found;
    stat.addr_ok       = (off[PageShift-1:0] == '0) &&
                         (off[AddrW-1:PageShift] < (AddrW-PageShift)'(pool_pages));
    stat.mode          = mode_q;
    stat.lvl_gt_rank   = lvl > rank_q;
    stat.lvl_below_max = lvl < RankW'(MaxRank);
    stat.buddy_in_pool = ({1'b0, 1'b0, b_c} + {1'b0, half}) <= {1'b0, pool_pages};
    stat.blk_ok        = rank_rd[RankW] && (rank_rd[RankW-1:0] != '0) &&
                         (rank_rd[RankW-1:0] <= RankW'(MaxRank));
    stat.rank_zero     = (rank_rd[RankW-1:0] == '0);
    stat.buddy_free    = !rank_rd[RankW] && (rank_rd[RankW-1:0] == lvl);
    stat.out_free      = !rsp_valid || rsp_ready;
  end

  always_comb begin
    nm_we = 1'b0;
    nm_wa = cur;
    nm_wd = '0;
    pm_we = 1'b0;
    pm_wa = cur;
    pm_wd = '0;
    rm_we = 1'b0;
    rm_wa = cur;
    rm_wd = '0;
    nm_ra = b;
    pm_ra = b;
    rm_ra = cur;
    unique case (cmd.op)
      OP_POP1: begin
        nm_ra = h[IdxW-1:0];
      end
      OP_POP2: begin
        if (next_rd[LinkW-1]) begin
          pm_we = 1'b1;
          pm_wa = next_rd[IdxW-1:0];
        end
      end
      OP_PUSH1: begin
        nm_we = 1'b1;
        nm_wa = push_a;
        nm_wd = h;
        if (h[LinkW-1]) begin
          pm_we = 1'b1;
          pm_wa = h[IdxW-1:0];
          pm_wd = {1'b1, push_a};
        end
      end
      OP_PUSH2: begin
        pm_we = 1'b1;
        pm_wa = push_a;
      end
      OP_UNLINK2: begin
        if (prev_rd[LinkW-1]) begin
          nm_we = 1'b1;
          nm_wa = prev_rd[IdxW-1:0];
          nm_wd = next_rd;
        end
        if (next_rd[LinkW-1]) begin
          pm_we = 1'b1;
          pm_wa = next_rd[IdxW-1:0];
          pm_wd = prev_rd;
        end
      end
      OP_RANGE_STEP: begin
        if (!rng_done) begin
          rm_we = 1'b1;
          rm_wa = rng_base + rng_cnt[IdxW-1:0];
          if (rng_sweep) begin
            rm_wd = {1'b0, (rng_cnt < top_size) ? top_rank : RankW'(0)};
          end else begin
            rm_wd = {1'b0, rng_val};
          end
        end
      end
      OP_MARK: begin
        rm_we = 1'b1;
        rm_wd = {1'b1, rank_q};
      end
      OP_FSTART: begin
        rm_we = 1'b1;
        rm_wd = {1'b0, rank_rd[RankW-1:0]};
      end
      OP_READ_CUR: begin
        rm_ra = idx_dec;
      end
      OP_READ_B: begin
        rm_ra = b_c;
      end
      default: begin
      end
    endcase
    if (pc_wr) begin
      nm_we = 1'b1;
      nm_wa = '0;
      nm_wd = '0;
      pm_we = 1'b1;
      pm_wa = '0;
      pm_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (nm_we) begin
      next_mem[nm_wa] <= nm_wd;
    end
    next_rd <= next_mem[nm_ra];
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      prev_mem[pm_wa] <= pm_wd;
    end
    prev_rd <= prev_mem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (rm_we) begin
      rank_mem[rm_wa] <= rm_wd;
    end
    rank_rd <= rank_mem[rm_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!pc_wr &&
                 (cmd.op inside {OP_RES_ERR, OP_RES_ALLOC, OP_RES_RANK, OP_RES_COUNT})) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_pages <= '0;
      top_rank   <= '0;
      lvl        <= '0;
      rng_len    <= '0;
      rng_cnt    <= '0;
      rng_sweep  <= 1'b0;
      for (int i = 0; i < MaxRank; i++) begin
        head[i]   <= '0;
        fcount[i] <= '0;
      end
    end else begin
      if (cfg_valid && (cfg_index == CFG_POOL_BASE)) begin
        pool_base <= cfg_data;
      end
      if (pc_wr) begin
        pool_pages <= pp_new;
        top_rank   <= top_new;
        for (int i = 0; i < MaxRank; i++) begin
          head[i]   <= (top_new == RankW'(i + 1)) ? {1'b1, IdxW'(0)} : '0;
          fcount[i] <= (top_new == RankW'(i + 1)) ? CntW'(1) : '0;
        end
        rng_base  <= '0;
        rng_len   <= pp_new;
        rng_cnt   <= '0;
        rng_sweep <= 1'b1;
      end else begin
        unique case (cmd.op)
          OP_LOAD: begin
            mode_q <= mode_t'(req_mode);
            rank_q <= req_rank;
            addr_q <= req_address;
          end
          OP_SETK:   lvl <= found_k;
          OP_POP1:   cur <= h[IdxW-1:0];
          OP_POP2: begin
            head[li]   <= next_rd;
            fcount[li] <= fcount[li] - 1'b1;
          end
          OP_PUSH2: begin
            head[li]   <= {1'b1, push_a};
            fcount[li] <= fcount[li] + 1'b1;
          end
          OP_UNLINK2: begin
            if (!prev_rd[LinkW-1]) begin
              head[li] <= next_rd;
            end
            fcount[li] <= fcount[li] - 1'b1;
          end
          OP_DEC:    lvl <= lvl - 5'd1;
          OP_RANGE_START: begin
            rng_base  <= cur;
            rng_len   <= cmd.dbl ? CntW'(17'd1 << lvl) : half;
            rng_cnt   <= '0;
            rng_val   <= lvl;
            rng_sweep <= 1'b0;
          end
          OP_RANGE_STEP: begin
            if (!rng_done) begin
              rng_cnt <= rng_cnt + 1'b1;
            end
          end
          OP_READ_CUR: cur <= idx_dec;
          OP_FSTART:   lvl <= rank_rd[RankW-1:0];
          OP_READ_B:   b <= b_c;
          OP_MERGE: begin
            if (b < cur) begin
              cur <= b;
            end
            lvl <= lvl + 5'd1;
          end
          OP_RES_ERR: begin
            rsp_status      <= cmd.res;
            rsp_block_addr  <= '0;
            rsp_query_value <= '0;
          end
          OP_RES_ALLOC: begin
            rsp_status      <= ST_OK;
            rsp_block_addr  <= pool_base + {(AddrW-IdxW-PageShift)'(0), cur,
                                            PageShift'(0)};
            rsp_query_value <= '0;
          end
          OP_RES_RANK: begin
            rsp_status      <= ST_OK;
            rsp_block_addr  <= '0;
            rsp_query_value <= {(CntW-RankW)'(0), rank_rd[RankW-1:0]};
          end
          OP_RES_COUNT: begin
            rsp_status      <= ST_OK;
            rsp_block_addr  <= '0;
            rsp_query_value <= fcount[qi];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* design/bpa_ctrl.sv */
// Controller state machine of the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_cmd_t       cmd
);
  import bpa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '{op: OP_NONE, res: ST_OK, sel_hi: 1'b0, dbl: 1'b0};
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.mode)
          MODE_ALLOC: begin
            if (!stat.rank_ok || !stat.found) begin
              if (stat.out_free) begin
                cmd.op     = OP_RES_ERR;
                cmd.res    = stat.rank_ok ? ST_NOSPACE : ST_INVALID;
                state_next = S_IDLE;
              end
            end else begin
              cmd.op     = OP_SETK;
              state_next = S_A_CHECK;
            end
          end
          MODE_FREE, MODE_QRANK: begin
            if (!stat.addr_ok) begin
              if (stat.out_free) begin
                cmd.op     = OP_RES_ERR;
                cmd.res    = ST_INVALID;
                state_next = S_IDLE;
              end
            end else begin
              cmd.op     = OP_READ_CUR;
              state_next = (stat.mode == MODE_FREE) ? S_F_RD : S_Q_RD;
            end
          end
          MODE_QCOUNT: begin
            if (stat.out_free) begin
              cmd.op     = stat.rank_ok ? OP_RES_COUNT : OP_RES_ERR;
              cmd.res    = ST_INVALID;
              state_next = S_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      S_SWEEP: begin
        if (stat.range_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_RANGE_STEP;
        end
      end
      S_A_CHECK: begin
        cmd.op     = OP_POP1;
        state_next = stat.lvl_gt_rank ? S_A_SPOP2 : S_A_FPOP2;
      end
      S_A_SPOP2: begin
        cmd.op     = OP_POP2;
        state_next = S_A_DEC;
      end
      S_A_DEC: begin
        cmd.op     = OP_DEC;
        state_next = S_A_PUSHH1;
      end
      S_A_PUSHH1: begin
        cmd.op     = OP_PUSH1;
        cmd.sel_hi = 1'b1;
        state_next = S_A_PUSHH2;
      end
      S_A_PUSHH2: begin
        cmd.op     = OP_PUSH2;
        cmd.sel_hi = 1'b1;
        state_next = S_A_PUSHL1;
      end
      S_A_PUSHL1: begin
        cmd.op     = OP_PUSH1;
        state_next = S_A_PUSHL2;
      end
      S_A_PUSHL2: begin
        cmd.op     = OP_PUSH2;
        state_next = S_A_RSTART;
      end
      S_A_RSTART: begin
        cmd.op     = OP_RANGE_START;
        cmd.dbl    = 1'b1;
        state_next = S_A_RANGE;
      end
      S_A_RANGE: begin
        if (stat.range_done) begin
          state_next = S_A_CHECK;
        end else begin
          cmd.op = OP_RANGE_STEP;
        end
      end
      S_A_FPOP2: begin
        cmd.op     = OP_POP2;
        state_next = S_A_MARK;
      end
      S_A_MARK: begin
        cmd.op     = OP_MARK;
        state_next = S_A_RES;
      end
      S_A_RES: begin
        if (stat.out_free) begin
          cmd.op     = OP_RES_ALLOC;
          state_next = S_IDLE;
        end
      end
      S_F_RD: begin
        if (stat.blk_ok) begin
          cmd.op     = OP_FSTART;
          state_next = S_F_CHECK;
        end else if (stat.out_free) begin
          cmd.op     = OP_RES_ERR;
          cmd.res    = ST_INVALID;
          state_next = S_IDLE;
        end
      end
      S_F_CHECK: begin
        if (stat.lvl_below_max && stat.buddy_in_pool) begin
          cmd.op     = OP_READ_B;
          state_next = S_F_BUD;
        end else begin
          cmd.op     = OP_PUSH1;
          state_next = S_F_PUSH2;
        end
      end
      S_F_BUD: begin
        if (stat.buddy_free) begin
          cmd.op     = OP_UNLINK1;
          state_next = S_F_UNL2;
        end else begin
          cmd.op     = OP_PUSH1;
          state_next = S_F_PUSH2;
        end
      end
      S_F_UNL2: begin
        cmd.op     = OP_UNLINK2;
        state_next = S_F_MERGE;
      end
      S_F_MERGE: begin
        cmd.op     = OP_MERGE;
        state_next = S_F_RSTART;
      end
      S_F_RSTART: begin
        cmd.op     = OP_RANGE_START;
        state_next = S_F_RANGE;
      end
      S_F_RANGE: begin
        if (stat.range_done) begin
          state_next = S_F_CHECK;
        end else begin
          cmd.op = OP_RANGE_STEP;
        end
      end
      S_F_PUSH2: begin
        cmd.op     = OP_PUSH2;
        state_next = S_F_RES;
      end
      S_F_RES: begin
        if (stat.out_free) begin
          cmd.op     = OP_RES_ERR;
          cmd.res    = ST_OK;
          state_next = S_IDLE;
        end
      end
      S_Q_RD: begin
        if (stat.out_free) begin
          cmd.op     = stat.rank_zero ? OP_RES_ERR : OP_RES_RANK;
          cmd.res    = ST_INVALID;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (stat.init_start) begin
      state_next = S_SWEEP;
    end
  end

endmodule
`default_nettype wire

/* design/buddy_page_allocator_top.sv */
// Top level of the buddy page allocator: controller, datapath and channel wiring.
// One item at a time. The result is registered soonest for a count query or an error found
// at dispatch, later for a rank query or a free of a non-start page; an allocate also rewrites
// the page ranks of each split block and a free those of each merged block before the result.
// The next item is taken only after the result is registered; a held result stalls the block.
// Reset leaves an empty pool; a page_count write starts a sweep over the pool pages, during
// which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module buddy_page_allocator_top (
  input  wire logic  clk,
  input  wire logic  rst,
  bpa_req_if.sink    req,
  bpa_rsp_if.source  rsp,
  bpa_cfg_if.sink    cfg
);
  import bpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_mode        (req.mode),
    .req_rank        (req.rank),
    .req_address     (req.address),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp.status),
    .rsp_block_addr  (rsp.block_addr),
    .rsp_query_value (rsp.query_value),
    .rsp_ready       (rsp.ready)
  );

endmodule
`default_nettype wire

/* tb/sv/buddy_page_allocator_top_test.sv */
// Self-checking testbench of the buddy page allocator with its own allocator predictor.
`timescale 1ns / 1ps
`default_nettype none
module buddy_page_allocator_top_test;
  import bpa_pkg::*;

  localparam int CycleLimit = 4000000;

  typedef struct {
    status_t     status;
    logic [47:0] block_addr;
    logic [15:0] query_value;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpa_req_if req ();
  bpa_rsp_if rsp ();
  bpa_cfg_if cfg ();

  buddy_page_allocator_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [47:0] pool_base;
  int          pool_pages;
  int          top_rank;
  logic [15:0] list_head [MaxRank+1];
  logic [15:0] free_blocks [MaxRank+1];
  logic [15:0] next_link [MaxPages];
  logic [15:0] prev_link [MaxPages];
  logic [4:0]  page_rank [MaxPages];
  bit          alloc_start [MaxPages];

  alloc_rsp_t  expected_q [$];
  int          live_pages [$];
  int          mismatches = 0;
  int          unexpected = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;

  function automatic void set_ranks(int first, int n, logic [4:0] r);
    for (int i = first; i < first + n && i < MaxPages; i++) page_rank[i] = r;
  endfunction

  function automatic void list_push(int r, int idx);
    logic [15:0] h;
    h = list_head[r];
    next_link[idx] = h;
    prev_link[idx] = 16'd0;
    if (h[15]) prev_link[h[14:0]] = {1'b1, 15'(idx)};
    list_head[r] = {1'b1, 15'(idx)};
    free_blocks[r]++;
  endfunction

  function automatic int list_pop(int r);
    int          idx;
    logic [15:0] n;
    idx = int'(list_head[r][14:0]);
    n = next_link[idx];
    list_head[r] = n;
    if (n[15]) prev_link[n[14:0]] = 16'd0;
    free_blocks[r]--;
    return idx;
  endfunction

  function automatic void list_unlink(int r, int idx);
    logic [15:0] p;
    logic [15:0] n;
    p = prev_link[idx];
    n = next_link[idx];
    if (p[15]) next_link[p[14:0]] = n;
    else list_head[r] = n;
    if (n[15]) prev_link[n[14:0]] = p;
    free_blocks[r]--;
  endfunction

  function automatic void pool_reinit(logic [15:0] count);
    for (int r = 0; r <= MaxRank; r++) begin
      list_head[r] = 16'd0;
      free_blocks[r] = 16'd0;
    end
    for (int i = 0; i < MaxPages; i++) begin
      next_link[i] = 16'd0;
      prev_link[i] = 16'd0;
      page_rank[i] = 5'd0;
      alloc_start[i] = 1'b0;
    end
    pool_pages = (count > MaxPages) ? MaxPages : int'(count);
    top_rank = 0;
    while (top_rank < MaxRank && (1 << top_rank) <= pool_pages) top_rank++;
    if (top_rank >= 1) begin
      list_push(top_rank, 0);
      set_ranks(0, 1 << (top_rank - 1), 5'(top_rank));
    end
    live_pages.delete();
  endfunction

  function automatic bit page_of(logic [47:0] address, output int idx);
    logic [47:0] off;
    off = address - pool_base;
    idx = 0;
    if (off[11:0] != 12'd0) return 1'b0;
    if ((off >> PageShift) >= pool_pages) return 1'b0;
    idx = int'(off >> PageShift);
    return 1'b1;
  endfunction

  function automatic alloc_rsp_t allocator_step(mode_t mode, logic [4:0] rank,
                                                logic [47:0] address);
    alloc_rsp_t res;
    int         idx;
    int         k;
    int         r;
    int         size;
    int         b;
    res.status = ST_OK;
    res.block_addr = '0;
    res.query_value = '0;
    case (mode)
      MODE_ALLOC: begin
        if (rank < 1 || rank > MaxRank) begin
          res.status = ST_INVALID;
        end else begin
          k = int'(rank);
          while (k <= MaxRank && !list_head[k][15]) k++;
          if (k > MaxRank) begin
            res.status = ST_NOSPACE;
          end else begin
            while (k > rank) begin
              size = 1 << (k - 2);
              idx = list_pop(k);
              list_push(k - 1, idx + size);
              list_push(k - 1, idx);
              set_ranks(idx, 2 * size, 5'(k - 1));
              k--;
            end
            idx = list_pop(rank);
            alloc_start[idx] = 1'b1;
            res.block_addr = pool_base + (48'(idx) << PageShift);
            live_pages.push_back(idx);
          end
        end
      end
      MODE_FREE: begin
        if (!page_of(address, idx) || !alloc_start[idx] ||
            page_rank[idx] < 1 || page_rank[idx] > MaxRank) begin
          res.status = ST_INVALID;
        end else begin
          foreach (live_pages[i]) begin
            if (live_pages[i] == idx) begin
              live_pages.delete(i);
              break;
            end
          end
          r = int'(page_rank[idx]);
          alloc_start[idx] = 1'b0;
          while (r < MaxRank) begin
            size = 1 << (r - 1);
            b = idx ^ size;
            if (b >= pool_pages || b + size > pool_pages) break;
            if (alloc_start[b] || page_rank[b] != r) break;
            list_unlink(r, b);
            if (b < idx) idx = b;
            r++;
            set_ranks(idx, 2 * size, 5'(r));
          end
          list_push(r, idx);
        end
      end
      MODE_QRANK: begin
        if (!page_of(address, idx) || page_rank[idx] == 5'd0) res.status = ST_INVALID;
        else res.query_value = 16'(page_rank[idx]);
      end
      default: begin
        if (rank < 1 || rank > MaxRank) res.status = ST_INVALID;
        else res.query_value = free_blocks[rank];
      end
    endcase
    return res;
  endfunction

  task automatic send_item(mode_t mode, logic [4:0] rank, logic [47:0] address);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.mode    <= mode;
    req.rank    <= rank;
    req.address <= address;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_q.push_back(allocator_step(mode, rank, address));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] index, logic [47:0] data);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (index == CFG_POOL_BASE) pool_base = data;
    else pool_reinit(data[15:0]);
  endtask

  function automatic logic [47:0] page_addr(int idx);
    return pool_base + (48'(idx) << PageShift);
  endfunction

  function automatic logic [47:0] random_addr();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic random_item();
    int          pick;
    int          sel;
    logic [4:0]  rank;
    pick = $urandom_range(0, 99);
    if (pick < 70 && pick >= 40 && live_pages.size() > 0) begin
      sel = $urandom_range(0, live_pages.size() - 1);
      send_item(MODE_FREE, 5'd0, page_addr(live_pages[sel]));
    end else if (pick < 70) begin
      rank = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(1, top_rank + 1))
                                         : 5'($urandom_range(1, 3));
      send_item(MODE_ALLOC, rank, random_addr());
    end else if (pick < 80) begin
      send_item(MODE_QRANK, 5'($urandom), page_addr($urandom_range(0, pool_pages)));
    end else if (pick < 88) begin
      send_item(MODE_QCOUNT, 5'($urandom_range(1, MaxRank)), random_addr());
    end else if (pick < 92) begin
      send_item(MODE_FREE, 5'($urandom),
                page_addr($urandom_range(0, pool_pages)) + 48'($urandom_range(0, 1)));
    end else begin
      send_item(mode_t'($urandom_range(0, 3)), 5'($urandom), random_addr());
    end
  endtask

  task automatic random_phase(int n);
    repeat (n) random_item();
  endtask

  task automatic test_empty_pool();
    send_item(MODE_ALLOC, 5'd1, '0);
    send_item(MODE_FREE, 5'd0, '0);
    send_item(MODE_QRANK, 5'd0, '0);
    send_item(MODE_QCOUNT, 5'd16, '0);
    send_item(MODE_QCOUNT, 5'd0, '1);
  endtask

  task automatic test_directed_small();
    cfg_write(CFG_POOL_BASE, 48'h0000_1234_5000);
    cfg_write(CFG_PAGE_COUNT, 48'd12);
    send_item(MODE_ALLOC, 5'd0, '0);
    send_item(MODE_ALLOC, 5'd17, '0);
    send_item(MODE_ALLOC, 5'd31, '1);
    send_item(MODE_ALLOC, 5'd1, '0);
    send_item(MODE_ALLOC, 5'd2, '0);
    send_item(MODE_QRANK, 5'd0, page_addr(1));
    send_item(MODE_QRANK, 5'd0, page_addr(9));
    send_item(MODE_QRANK, 5'd0, page_addr(12));
    send_item(MODE_QRANK, 5'd0, page_addr(0) + 48'd1);
    send_item(MODE_QCOUNT, 5'd1, '0);
    send_item(MODE_QCOUNT, 5'd3, '0);
    send_item(MODE_FREE, 5'd0, page_addr(0));
    send_item(MODE_FREE, 5'd0, page_addr(0));
    send_item(MODE_FREE, 5'd0, page_addr(3));
    send_item(MODE_FREE, 5'd0, page_addr(2));
    send_item(MODE_ALLOC, 5'd4, '0);
    send_item(MODE_ALLOC, 5'd4, '0);
    send_item(MODE_ALLOC, 5'd5, '0);
    send_item(MODE_FREE, 5'd0, page_addr(0) - 48'd4096);
    send_item(MODE_FREE, 5'd0, page_addr(0));
    send_item(MODE_QCOUNT, 5'd4, '0);
    cfg_write(CFG_PAGE_COUNT, 48'd1);
    send_item(MODE_QRANK, 5'd0, page_addr(0));
    send_item(MODE_ALLOC, 5'd1, '0);
    send_item(MODE_ALLOC, 5'd1, '0);
    send_item(MODE_FREE, 5'd0, page_addr(0));
  endtask

  task automatic test_large_pool();
    cfg_write(CFG_POOL_BASE, 48'd0);
    cfg_write(CFG_PAGE_COUNT, 48'd32768);
    send_item(MODE_ALLOC, 5'd1, '0);
    send_item(MODE_QCOUNT, 5'd15, '0);
    send_item(MODE_QRANK, 5'd0, page_addr(32767));
    send_item(MODE_FREE, 5'd0, page_addr(0));
    send_item(MODE_ALLOC, 5'd16, '0);
    send_item(MODE_ALLOC, 5'd16, '0);
    send_item(MODE_FREE, 5'd0, page_addr(0));
    cfg_write(CFG_PAGE_COUNT, 48'hFFFF);
    send_item(MODE_QCOUNT, 5'd16, '0);
    send_item(MODE_QRANK, 5'd0, page_addr(32768));
  endtask

  task automatic test_base_wrap();
    cfg_write(CFG_PAGE_COUNT, 48'd40);
    cfg_write(CFG_POOL_BASE, 48'hFFFF_FFFF_E000);
    random_phase(60);
    cfg_write(CFG_POOL_BASE, 48'hFFFF_FFFF_FFFF);
    random_phase(40);
  endtask

  task automatic test_random_pools();
    repeat (8) begin
      cfg_write(CFG_POOL_BASE, random_addr());
      cfg_write(CFG_PAGE_COUNT, 48'($urandom_range(2, 300)));
      random_phase(80);
    end
  endtask

  task automatic test_backpressure();
    cfg_write(CFG_PAGE_COUNT, 48'd64);
    hold_cycles = 400;
    random_phase(30);
    drain();
    random_phase(40);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    cfg_write(CFG_POOL_BASE, 48'h7FFF_0000_0000);
    cfg_write(CFG_PAGE_COUNT, 48'd128);
    random_phase(120);
  endtask

  initial begin
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        rsp.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("Unexpected result item: status %0d addr %h value %0d",
                   rsp.status, rsp.block_addr, rsp.query_value);
      end else begin
        exp_rsp = expected_q.pop_front();
        if (rsp.status !== exp_rsp.status || rsp.block_addr !== exp_rsp.block_addr ||
            rsp.query_value !== exp_rsp.query_value) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("Mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                     exp_rsp.status, exp_rsp.block_addr, exp_rsp.query_value,
                     rsp.status, rsp.block_addr, rsp.query_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    req.valid   <= 1'b0;
    req.mode    <= MODE_ALLOC;
    req.rank    <= '0;
    req.address <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= CFG_POOL_BASE;
    cfg.data    <= '0;
    pool_base = '0;
    pool_reinit(16'd0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pool();
    test_directed_small();
    test_large_pool();
    test_base_wrap();
    test_random_pools();
    test_backpressure();
    test_no_idle();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
